// ===== rtl/core/ptzfe_pkg.sv =====
// ptzfe_pkg: shared types, opcodes and frame constants for the PTZ command
// frame encoder. No dependencies.
package ptzfe_pkg;

   localparam int FRAME_LENGTH = 7;
   localparam int AUX_COUNT    = 8;
   localparam int POS_W        = $clog2(FRAME_LENGTH);
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LEVEL    = 1'd1;

   // opcodes
   localparam logic [4:0] OP_STOP          = 5'd0;
   localparam logic [4:0] OP_LEFT          = 5'd1;
   localparam logic [4:0] OP_RIGHT         = 5'd2;
   localparam logic [4:0] OP_UP            = 5'd3;
   localparam logic [4:0] OP_DOWN          = 5'd4;
   localparam logic [4:0] OP_LEFT_UP       = 5'd5;
   localparam logic [4:0] OP_LEFT_DOWN     = 5'd6;
   localparam logic [4:0] OP_RIGHT_UP      = 5'd7;
   localparam logic [4:0] OP_RIGHT_DOWN    = 5'd8;
   localparam logic [4:0] OP_IRIS_OPEN     = 5'd9;
   localparam logic [4:0] OP_IRIS_CLOSE    = 5'd10;
   localparam logic [4:0] OP_FOCUS_FAR     = 5'd11;
   localparam logic [4:0] OP_FOCUS_NEAR    = 5'd12;
   localparam logic [4:0] OP_ZOOM_OUT      = 5'd13;
   localparam logic [4:0] OP_ZOOM_IN       = 5'd14;
   localparam logic [4:0] OP_PRESET_GO     = 5'd15;
   localparam logic [4:0] OP_PRESET_SET    = 5'd16;
   localparam logic [4:0] OP_SCAN_99       = 5'd17;
   localparam logic [4:0] OP_SCAN_97       = 5'd18;
   localparam logic [4:0] OP_SCAN_STOP     = 5'd19;
   localparam logic [4:0] OP_CRUISE_RUN    = 5'd20;
   localparam logic [4:0] OP_CRUISE_STOP   = 5'd21;
   localparam logic [4:0] OP_CRUISE_DELETE = 5'd22;
   localparam logic [4:0] OP_CRUISE_ENTER  = 5'd23;
   localparam logic [4:0] OP_CRUISE_CONFIG = 5'd24;
   localparam logic [4:0] OP_CRUISE_LEAVE  = 5'd25;
   localparam logic [4:0] OP_TRACK_REC     = 5'd26;
   localparam logic [4:0] OP_TRACK_REC_END = 5'd27;
   localparam logic [4:0] OP_TRACK_START   = 5'd28;
   localparam logic [4:0] OP_TRACK_STOP    = 5'd29;
   localparam logic [4:0] OP_AUX_SET       = 5'd30;
   localparam logic [4:0] OP_AUX_CLEAR     = 5'd31;

   // frame bytes
   localparam logic [7:0] SYNC_BYTE     = 8'hFF;
   localparam logic [7:0] PRESET_SCAN_A = 8'h63;
   localparam logic [7:0] PRESET_SCAN_B = 8'd97;
   localparam logic [7:0] PRESET_SCAN_C = 8'd96;
   localparam logic [7:0] CRUISE_BASE   = 8'h09;

   typedef struct packed {
      logic [4:0] opcode;
      logic [7:0] argument;
      logic [3:0] cruise_speed;
      logic [7:0] wait_time;
   } cmd_type;

   typedef struct packed {
      logic [7:0] device_address;
      logic [3:0] speed_level;
   } cfg_type;

   typedef struct packed {
      logic [FRAME_LENGTH-1:0][7:0] bytes;
      logic                         rejected;
   } frame_type;

endpackage

// ===== rtl/core/ptzfe_encode.sv =====
// ptzfe_encode: combinational frame builder, command bytes and checksum.
// Depends on ptzfe_pkg.
module ptzfe_encode (
   input  ptzfe_pkg::cmd_type   cmd,
   input  ptzfe_pkg::cfg_type   cfg,
   output ptzfe_pkg::frame_type frame
);

   logic [7:0] spd;
   logic [7:0] c1;
   logic [7:0] c2;
   logic [7:0] d1;
   logic [7:0] d2;
   logic [7:0] arg_inc;
   logic       aux_bad;

   assign spd     = (8'(cfg.speed_level) << 3) - 8'd1;
   assign arg_inc = cmd.argument + 8'd1;
   assign aux_bad = (cmd.argument < 8'd1) ||
                    (cmd.argument > 8'(ptzfe_pkg::AUX_COUNT));

   always_comb begin
      c1 = 8'h00;
      c2 = 8'h00;
      d1 = 8'h00;
      d2 = 8'h00;
      frame.rejected = 1'b0;
      case (cmd.opcode)
         ptzfe_pkg::OP_STOP:          ;
         ptzfe_pkg::OP_LEFT:          begin c2 = 8'h04; d1 = spd; end
         ptzfe_pkg::OP_RIGHT:         begin c2 = 8'h02; d1 = spd; end
         ptzfe_pkg::OP_UP:            begin c2 = 8'h08; d2 = spd; end
         ptzfe_pkg::OP_DOWN:          begin c2 = 8'h10; d2 = spd; end
         ptzfe_pkg::OP_LEFT_UP:       begin c2 = 8'h0C; d1 = spd; d2 = spd; end
         ptzfe_pkg::OP_LEFT_DOWN:     begin c2 = 8'h14; d1 = spd; d2 = spd; end
         ptzfe_pkg::OP_RIGHT_UP:      begin c2 = 8'h0A; d1 = spd; d2 = spd; end
         ptzfe_pkg::OP_RIGHT_DOWN:    begin c2 = 8'h12; d1 = spd; d2 = spd; end
         ptzfe_pkg::OP_IRIS_OPEN:     c1 = 8'h02;
         ptzfe_pkg::OP_IRIS_CLOSE:    c1 = 8'h04;
         ptzfe_pkg::OP_FOCUS_FAR:     c2 = 8'h80;
         ptzfe_pkg::OP_FOCUS_NEAR:    c1 = 8'h01;
         ptzfe_pkg::OP_ZOOM_OUT:      c2 = 8'h20;
         ptzfe_pkg::OP_ZOOM_IN:       c2 = 8'h40;
         ptzfe_pkg::OP_PRESET_GO:     begin c2 = 8'h07; d2 = arg_inc; end
         ptzfe_pkg::OP_PRESET_SET:    begin c2 = 8'h03; d2 = arg_inc; end
         ptzfe_pkg::OP_SCAN_99:       begin c2 = 8'h07; d2 = ptzfe_pkg::PRESET_SCAN_A; end
         ptzfe_pkg::OP_SCAN_97:       begin c2 = 8'h07; d2 = ptzfe_pkg::PRESET_SCAN_B; end
         ptzfe_pkg::OP_SCAN_STOP:     begin c2 = 8'h07; d2 = ptzfe_pkg::PRESET_SCAN_C; end
         ptzfe_pkg::OP_CRUISE_RUN:    begin c2 = 8'h4F; d1 = 8'h01; d2 = cmd.argument; end
         ptzfe_pkg::OP_CRUISE_STOP:   c2 = 8'h51;
         ptzfe_pkg::OP_CRUISE_DELETE: begin c2 = 8'h4D; d2 = cmd.argument; end
         ptzfe_pkg::OP_CRUISE_ENTER:  begin c2 = 8'h47; d2 = cmd.argument; end
         ptzfe_pkg::OP_CRUISE_CONFIG: begin
            // all-zero arguments leave the preset byte at zero
            c1 = (cmd.argument == 8'd0 && cmd.cruise_speed == 4'd0 &&
                  cmd.wait_time == 8'd0) ? 8'h00 : arg_inc;
            c2 = 8'h49;
            d1 = ptzfe_pkg::CRUISE_BASE - 8'(cmd.cruise_speed);
            d2 = cmd.wait_time;
         end
         ptzfe_pkg::OP_CRUISE_LEAVE:  c2 = 8'h4B;
         ptzfe_pkg::OP_TRACK_REC:     c2 = 8'h1F;
         ptzfe_pkg::OP_TRACK_REC_END: c2 = 8'h21;
         ptzfe_pkg::OP_TRACK_START:   c2 = 8'h23;
         ptzfe_pkg::OP_TRACK_STOP:    c2 = 8'h04;
         ptzfe_pkg::OP_AUX_SET:       begin
            c2 = 8'h09; d2 = cmd.argument; frame.rejected = aux_bad;
         end
         ptzfe_pkg::OP_AUX_CLEAR:     begin
            c2 = 8'h0B; d2 = cmd.argument; frame.rejected = aux_bad;
         end
         default: ;
      endcase
      frame.bytes[0] = ptzfe_pkg::SYNC_BYTE;
      frame.bytes[1] = cfg.device_address;
      frame.bytes[2] = c1;
      frame.bytes[3] = c2;
      frame.bytes[4] = d1;
      frame.bytes[5] = d2;
      frame.bytes[6] = cfg.device_address + c1 + c2 + d1 + d2;
   end

endmodule

// ===== rtl/core/ptzfe_serial.sv =====
// ptzfe_serial: frame register and byte sequencer driving the result channel.
// Depends on ptzfe_pkg.
module ptzfe_serial (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  ptzfe_pkg::frame_type frame,
   output logic                 load_ok,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_frame_byte,
   output logic                 rsp_last_byte,
   output logic                 rsp_rejected
);

   localparam logic [ptzfe_pkg::POS_W-1:0] LAST_POS =
      ptzfe_pkg::POS_W'(ptzfe_pkg::FRAME_LENGTH - 1);

   logic [ptzfe_pkg::FRAME_LENGTH-1:0][7:0] bytes_ff, bytes_in;
   logic [ptzfe_pkg::POS_W-1:0]             pos_ff, pos_in;
   logic                                    busy_ff, busy_in;
   logic                                    rej_ff, rej_in;
   logic                                    advance;

   assign rsp_valid      = busy_ff;
   assign rsp_frame_byte = bytes_ff[0];
   assign rsp_rejected   = rej_ff;
   assign rsp_last_byte  = rej_ff || (pos_ff == LAST_POS);
   assign advance        = busy_ff && rsp_ready;
   assign load_ok        = !busy_ff || (rsp_ready && rsp_last_byte);

   always_comb begin
      bytes_in = bytes_ff;
      pos_in   = pos_ff;
      busy_in  = busy_ff;
      rej_in   = rej_ff;
      if (load) begin
         // a rejection is a single zero byte
         bytes_in = frame.rejected ? '0 : frame.bytes;
         pos_in   = '0;
         busy_in  = 1'b1;
         rej_in   = frame.rejected;
      end else if (advance) begin
         if (rsp_last_byte) begin
            busy_in = 1'b0;
         end else begin
            bytes_in = {8'h00, bytes_ff[ptzfe_pkg::FRAME_LENGTH-1:1]};
            pos_in   = pos_ff + ptzfe_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (reset) begin
         pos_ff  <= '0;
         busy_ff <= 1'b0;
         rej_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
         rej_ff  <= rej_in;
      end
   end

endmodule

// ===== rtl/core/ptz_command_frame_encoder.sv =====
// PTZ command frame encoder. Each accepted command item yields a seven-byte
// frame (sync 0xFF, device address, two command bytes, two data bytes and a
// checksum over bytes one to five) delivered one byte per result item, with
// last_byte on the checksum. Aux set/clear with a switch number outside 1..8
// yields one result item only: byte 0, last_byte 1, rejected 1. Frame bytes
// go out one byte per cycle while rsp_ready is high. The byte sequencer is
// the limit: one command item is held in the input register while a frame is
// sent, and the next frame is loaded in the cycle its predecessor's last byte
// is taken, so frames follow one another with no gap. When the block is
// empty, an accepted command passes through the input register and then the
// frame register before its first byte appears. Configuration (index 0
// device address, index 1 speed level, low four bits) is applied as frames
// are built; write it only while the block is idle.
// Depends on ptzfe_pkg, ptzfe_encode and ptzfe_serial.
module ptz_command_frame_encoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [4:0]                        req_opcode,
   input  logic [7:0]                        req_argument,
   input  logic [3:0]                        req_cruise_speed,
   input  logic [7:0]                        req_wait_time,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_frame_byte,
   output logic                              rsp_last_byte,
   output logic                              rsp_rejected,
   input  logic                              csr_write,
   input  logic [ptzfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptzfe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ptzfe_pkg::cmd_type   cmd_ff, cmd_in;
   logic                 cmd_valid_ff, cmd_valid_in;
   ptzfe_pkg::cfg_type   cfg_ff, cfg_in;
   ptzfe_pkg::frame_type frame;
   logic                 load_ok;
   logic                 load;

   // Hand the held item to the sequencer as soon as it can take a frame.
   assign load      = cmd_valid_ff && load_ok;
   assign req_ready = !cmd_valid_ff || load_ok;

   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      if (load) begin
         cmd_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         cmd_in.opcode       = req_opcode;
         cmd_in.argument     = req_argument;
         cmd_in.cruise_speed = req_cruise_speed;
         cmd_in.wait_time    = req_wait_time;
         cmd_valid_in        = 1'b1;
      end
   end

   // Configuration registers: take the write at once, drop unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ptzfe_pkg::CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_wdata;
            ptzfe_pkg::CSR_SPEED_LEVEL:    cfg_in.speed_level    = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         cfg_ff.device_address <= 8'd1;
         cfg_ff.speed_level    <= 4'd4;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   ptzfe_encode u_encode (
      .cmd   (cmd_ff),
      .cfg   (cfg_ff),
      .frame (frame)
   );

   ptzfe_serial u_serial (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .frame          (frame),
      .load_ok        (load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte),
      .rsp_rejected   (rsp_rejected)
   );

endmodule

// ===== rtl/core/ptzfe_checker.sv =====
// ptzfe_checker: port-level assertions on the result channel of the encoder,
// bound to ptz_command_frame_encoder. Depends on nothing else.
module ptzfe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte,
   input logic       rsp_rejected
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped before it was taken");

   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_last_byte)
      else $error("rejection not marked as last byte");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_frame_byte == 8'h00)
      else $error("rejection carries a non-zero byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ptz_command_frame_encoder ptzfe_checker u_ptzfe_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_last_byte  (rsp_last_byte),
   .rsp_rejected   (rsp_rejected)
);

// ===== test/ptz_command_frame_encoder_tb.sv =====
// Self-checking testbench for ptz_command_frame_encoder: predicts each command's
// seven-byte frame (or its rejection item) and checks every byte on the result channel.
// Depends on ptzfe_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module ptz_command_frame_encoder_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
      logic       rejected;
   } frame_beat_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic                              clock            = 1'b0;
   logic                              reset            = 1'b1;
   logic                              req_valid        = 1'b0;
   logic                              req_ready;
   logic [4:0]                        req_opcode       = '0;
   logic [7:0]                        req_argument     = '0;
   logic [3:0]                        req_cruise_speed = '0;
   logic [7:0]                        req_wait_time    = '0;
   logic                              rsp_valid;
   logic                              rsp_ready        = 1'b0;
   logic [7:0]                        rsp_frame_byte;
   logic                              rsp_last_byte;
   logic                              rsp_rejected;
   logic                              csr_write        = 1'b0;
   logic [ptzfe_pkg::CSR_INDEX_W-1:0] csr_index        = ptzfe_pkg::CSR_DEVICE_ADDRESS;
   logic [ptzfe_pkg::CSR_DATA_W-1:0]  csr_wdata        = '0;

   // Predictor copy of the two registers, at their reset values.
   logic [7:0] address_setting = 8'd1;
   logic [3:0] level_setting   = 4'd4;

   frame_beat_type frame_bytes_due[$];

   int             fail_count     = 0;
   int             commands_sent  = 0;
   int             bytes_checked  = 0;
   int             rejects_seen   = 0;
   int             settings_used  = 0;
   int             burst_left     = 0;
   int             idle_cycles    = 0;
   logic [31:0]    opcodes_seen   = '0;
   int             ready_tick     = 0;
   ready_mode_type ready_mode     = READY_ALWAYS;

   ptz_command_frame_encoder i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_argument     (req_argument),
      .req_cruise_speed (req_cruise_speed),
      .req_wait_time    (req_wait_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_rejected     (rsp_rejected),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Build the frame a command should produce under the current register copy and
   // queue its bytes. An aux command with a switch number outside 1..AUX_COUNT queues
   // a single rejection item instead and leaves nothing else behind.
   task automatic encode_command(input ptzfe_pkg::cmd_type cmd);
      logic [7:0] speed_byte;
      logic [7:0] cmd1;
      logic [7:0] cmd2;
      logic [7:0] data1;
      logic [7:0] data2;
      logic [7:0] checksum;
      speed_byte = {1'b0, level_setting, 3'b000} - 8'd1;   // level 0 wraps to 0xFF
      cmd1  = 8'h00;
      cmd2  = 8'h00;
      data1 = 8'h00;
      data2 = 8'h00;
      case (cmd.opcode)
         ptzfe_pkg::OP_STOP: ;
         ptzfe_pkg::OP_LEFT: begin
            cmd2 = 8'h04; data1 = speed_byte;
         end
         ptzfe_pkg::OP_RIGHT: begin
            cmd2 = 8'h02; data1 = speed_byte;
         end
         ptzfe_pkg::OP_UP: begin
            cmd2 = 8'h08; data2 = speed_byte;
         end
         ptzfe_pkg::OP_DOWN: begin
            cmd2 = 8'h10; data2 = speed_byte;
         end
         ptzfe_pkg::OP_LEFT_UP: begin
            cmd2 = 8'h0C; data1 = speed_byte; data2 = speed_byte;
         end
         ptzfe_pkg::OP_LEFT_DOWN: begin
            cmd2 = 8'h14; data1 = speed_byte; data2 = speed_byte;
         end
         ptzfe_pkg::OP_RIGHT_UP: begin
            cmd2 = 8'h0A; data1 = speed_byte; data2 = speed_byte;
         end
         ptzfe_pkg::OP_RIGHT_DOWN: begin
            cmd2 = 8'h12; data1 = speed_byte; data2 = speed_byte;
         end
         ptzfe_pkg::OP_IRIS_OPEN:  cmd1 = 8'h02;
         ptzfe_pkg::OP_IRIS_CLOSE: cmd1 = 8'h04;
         ptzfe_pkg::OP_FOCUS_FAR:  cmd2 = 8'h80;
         ptzfe_pkg::OP_FOCUS_NEAR: cmd1 = 8'h01;
         ptzfe_pkg::OP_ZOOM_OUT:   cmd2 = 8'h20;
         ptzfe_pkg::OP_ZOOM_IN:    cmd2 = 8'h40;
         ptzfe_pkg::OP_PRESET_GO: begin
            cmd2 = 8'h07; data2 = cmd.argument + 8'd1;
         end
         ptzfe_pkg::OP_PRESET_SET: begin
            cmd2 = 8'h03; data2 = cmd.argument + 8'd1;
         end
         ptzfe_pkg::OP_SCAN_99: begin
            cmd2 = 8'h07; data2 = ptzfe_pkg::PRESET_SCAN_A;
         end
         ptzfe_pkg::OP_SCAN_97: begin
            cmd2 = 8'h07; data2 = ptzfe_pkg::PRESET_SCAN_B;
         end
         ptzfe_pkg::OP_SCAN_STOP: begin
            cmd2 = 8'h07; data2 = ptzfe_pkg::PRESET_SCAN_C;
         end
         ptzfe_pkg::OP_CRUISE_RUN: begin
            cmd2 = 8'h4F; data1 = 8'h01; data2 = cmd.argument;
         end
         ptzfe_pkg::OP_CRUISE_STOP: cmd2 = 8'h51;
         ptzfe_pkg::OP_CRUISE_DELETE: begin
            cmd2 = 8'h4D; data2 = cmd.argument;
         end
         ptzfe_pkg::OP_CRUISE_ENTER: begin
            cmd2 = 8'h47; data2 = cmd.argument;
         end
         ptzfe_pkg::OP_CRUISE_CONFIG: begin
            // the preset is bumped by one unless all three fields are zero
            if (cmd.argument == 8'd0 && cmd.cruise_speed == 4'd0 && cmd.wait_time == 8'd0)
               cmd1 = 8'h00;
            else
               cmd1 = cmd.argument + 8'd1;
            cmd2  = 8'h49;
            data1 = ptzfe_pkg::CRUISE_BASE - {4'b0000, cmd.cruise_speed};
            data2 = cmd.wait_time;
         end
         ptzfe_pkg::OP_CRUISE_LEAVE:  cmd2 = 8'h4B;
         ptzfe_pkg::OP_TRACK_REC:     cmd2 = 8'h1F;
         ptzfe_pkg::OP_TRACK_REC_END: cmd2 = 8'h21;
         ptzfe_pkg::OP_TRACK_START:   cmd2 = 8'h23;
         ptzfe_pkg::OP_TRACK_STOP:    cmd2 = 8'h04;
         default: begin
            if (cmd.argument < 1 || cmd.argument > ptzfe_pkg::AUX_COUNT) begin
               frame_bytes_due.push_back('{8'h00, 1'b1, 1'b1});
               return;
            end
            cmd2  = (cmd.opcode == ptzfe_pkg::OP_AUX_SET) ? 8'h09 : 8'h0B;
            data2 = cmd.argument;
         end
      endcase
      checksum = address_setting + cmd1 + cmd2 + data1 + data2;
      frame_bytes_due.push_back('{ptzfe_pkg::SYNC_BYTE, 1'b0, 1'b0});
      frame_bytes_due.push_back('{address_setting,      1'b0, 1'b0});
      frame_bytes_due.push_back('{cmd1,                 1'b0, 1'b0});
      frame_bytes_due.push_back('{cmd2,                 1'b0, 1'b0});
      frame_bytes_due.push_back('{data1,                1'b0, 1'b0});
      frame_bytes_due.push_back('{data2,                1'b0, 1'b0});
      frame_bytes_due.push_back('{checksum,             1'b1, 1'b0});
   endtask

   // Offer one command and hold it until accepted. Valid stays high afterwards so
   // that a following item in the same burst goes out without a bubble; the gap
   // between bursts is taken here, before the next item is driven.
   task automatic send_command(input ptzfe_pkg::cmd_type cmd);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         // mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_opcode       <= cmd.opcode;
      req_argument     <= cmd.argument;
      req_cruise_speed <= cmd.cruise_speed;
      req_wait_time    <= cmd.wait_time;
      do
         @(posedge clock);
      while (!req_ready);
      encode_command(cmd);
      opcodes_seen[cmd.opcode] = 1'b1;
      commands_sent++;
   endtask

   // Drop valid and hold off until every queued byte has been taken, then let
   // the pipeline settle.
   task automatic drain_encoder();
      req_valid  <= 1'b0;
      burst_left = 0;
      do
         @(posedge clock);
      while (frame_bytes_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on back-to-back cycles; call only with the block idle.
   task automatic apply_settings(input logic [7:0] address, input logic [7:0] level_word);
      csr_write <= 1'b1;
      csr_index <= ptzfe_pkg::CSR_DEVICE_ADDRESS;
      csr_wdata <= address;
      @(posedge clock);
      csr_index <= ptzfe_pkg::CSR_SPEED_LEVEL;
      csr_wdata <= level_word;
      @(posedge clock);
      csr_write <= 1'b0;
      address_setting = address;
      level_setting   = level_word[3:0];   // only the low nibble is kept
      settings_used++;
      @(posedge clock);
   endtask

   function automatic ptzfe_pkg::cmd_type random_command();
      ptzfe_pkg::cmd_type cmd;
      cmd.opcode       = 5'($urandom_range(0, 31));
      cmd.argument     = 8'($urandom);
      cmd.cruise_speed = 4'($urandom);
      cmd.wait_time    = 8'($urandom);
      // steer aux numbers mostly into range so both outcomes turn up often
      if (cmd.opcode inside {ptzfe_pkg::OP_AUX_SET, ptzfe_pkg::OP_AUX_CLEAR} &&
          $urandom_range(0, 3) != 0)
         cmd.argument = 8'($urandom_range(1, ptzfe_pkg::AUX_COUNT));
      if (cmd.opcode inside {ptzfe_pkg::OP_AUX_SET, ptzfe_pkg::OP_AUX_CLEAR} &&
          $urandom_range(0, 5) == 0)
         cmd.argument = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'(ptzfe_pkg::AUX_COUNT + 1);
      if (cmd.opcode == ptzfe_pkg::OP_CRUISE_CONFIG && $urandom_range(0, 4) == 0) begin
         cmd.argument     = 8'd0;
         cmd.cruise_speed = 4'd0;
         cmd.wait_time    = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd1;
      end
      if (cmd.opcode inside {ptzfe_pkg::OP_PRESET_GO, ptzfe_pkg::OP_PRESET_SET} &&
          $urandom_range(0, 5) == 0)
         cmd.argument = 8'hFF;
      return cmd;
   endfunction

   // Every opcode once under the reset register values, with the fields at their
   // maxima for most opcodes, then the boundary cases around cruise config and aux range.
   task automatic test_opcode_sweep();
      ptzfe_pkg::cmd_type cmd;
      for (int op = 0; op < 32; op++) begin
         cmd = '{5'(op), 8'hFF, 4'hF, 8'hFF};
         case (cmd.opcode)
            ptzfe_pkg::OP_STOP:          cmd = '{ptzfe_pkg::OP_STOP, 8'h00, 4'h0, 8'h00};
            ptzfe_pkg::OP_PRESET_SET:    cmd.argument = 8'h00;
            ptzfe_pkg::OP_CRUISE_CONFIG: begin
               cmd = '{ptzfe_pkg::OP_CRUISE_CONFIG, 8'h00, 4'h0, 8'h00};
            end
            ptzfe_pkg::OP_AUX_SET:       cmd.argument = 8'd0;
            ptzfe_pkg::OP_AUX_CLEAR:     cmd.argument = 8'(ptzfe_pkg::AUX_COUNT + 1);
            default: ;
         endcase
         send_command(cmd);
      end
      send_command('{ptzfe_pkg::OP_CRUISE_CONFIG, 8'h00, 4'hF, 8'h00});
      send_command('{ptzfe_pkg::OP_AUX_SET, 8'(ptzfe_pkg::AUX_COUNT), 4'h0, 8'h00});
      send_command('{ptzfe_pkg::OP_AUX_CLEAR, 8'd1, 4'h0, 8'h00});
      drain_encoder();
   endtask

   // Run the register extremes, including a speed level of zero that wraps the speed byte.
   task automatic test_register_extremes();
      logic [7:0]         addresses[4]   = '{8'h00, 8'hFF, 8'hA5, 8'h5A};
      logic [7:0]         level_words[4] = '{8'h00, 8'hFF, 8'hF1, 8'h08};
      ptzfe_pkg::cmd_type cmd;
      for (int s = 0; s < 4; s++) begin
         apply_settings(addresses[s], level_words[s]);
         repeat (8) begin
            cmd = random_command();
            if ($urandom_range(0, 1) == 0)
               cmd.opcode = 5'($urandom_range(ptzfe_pkg::OP_LEFT, ptzfe_pkg::OP_RIGHT_DOWN));
            send_command(cmd);
         end
         drain_encoder();
      end
   endtask

   // Long random run; registers change between phases, and once mid-phase the
   // sender holds off until the encoder has emptied.
   task automatic test_random_traffic();
      for (int n = 0; n < 390; n++) begin
         if (n % 100 == 0) begin
            drain_encoder();
            apply_settings(8'($urandom), 8'($urandom_range(1, 8)));
         end else if (n % 100 == 50) begin
            drain_encoder();
         end
         send_command(random_command());
      end
   endtask

   // Receiver stall pattern: switch at random among always-ready, coin-toss, sparse
   // and a fixed one-in-five stall.
   always @(posedge clock) begin
      ready_tick <= ready_tick + 1;
      if (ready_tick % 64 == 0)
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
      case (ready_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_HALF:     rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
         READY_PERIODIC: rsp_ready <= (ready_tick % 5 != 3);
         default:        rsp_ready <= 1'b1;
      endcase
   end

   // Compare each byte taken with the oldest byte still owed.
   always @(posedge clock) begin
      frame_beat_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            $error("unexpected item on result channel: frame_byte %0h last %0b rejected %0b",
                   rsp_frame_byte, rsp_last_byte, rsp_rejected);
            fail_count++;
         end else begin
            due = frame_bytes_due.pop_front();
            if (rsp_frame_byte !== due.value) begin
               $error("frame_byte: expected %0h, got %0h", due.value, rsp_frame_byte);
               fail_count++;
            end
            if (rsp_last_byte !== due.last) begin
               $error("last_byte: expected %0b, got %0b", due.last, rsp_last_byte);
               fail_count++;
            end
            if (rsp_rejected !== due.rejected) begin
               $error("rejected: expected %0b, got %0b", due.rejected, rsp_rejected);
               fail_count++;
            end
            if (due.rejected)
               rejects_seen++;
            bytes_checked++;
         end
      end
   end

   // Abort if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d bytes still owed",
                  WATCHDOG_LIMIT, frame_bytes_due.size());
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_opcode_sweep();
      test_register_extremes();
      test_random_traffic();

      // release the last item, collect what is owed, then watch for strays
      drain_encoder();
      repeat (10) @(posedge clock);

      $display("Run covered %0d commands (%0d of 32 opcodes) under %0d register settings,",
               commands_sent, $countones(opcodes_seen), settings_used + 1);
      $display("checking %0d result items, %0d of them aux rejections.",
               bytes_checked, rejects_seen);
      if (fail_count == 0 && frame_bytes_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
